FILE: hw/rtl/mhi_pkg.sv
// Shared constants and types for the hard-iron calibrator.
package mhi_pkg;

	localparam int MAG_BITS   = 13;
	localparam int ANGLE_BITS = 40;
	localparam int OUT_BITS   = MAG_BITS + 1;
	localparam int PROD_BITS  = 33;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 36;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_LEVEL   = 3'd1,
		PH_WAIT    = 3'd2,
		PH_UPRIGHT = 3'd3,
		PH_CHECK   = 3'd4,
		PH_FAIL    = 3'd5,
		PH_SUCCESS = 3'd6,
		PH_SPARE   = 3'd7
	} phase_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_STEP_TIME  = 3'd0,
		REG_TURN_LIMIT = 3'd1,
		REG_LEVEL      = 3'd2,
		REG_HOLD       = 3'd3,
		REG_ROUND_TOL  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] step_time;
		logic [35:0] turn_limit;
		logic [14:0] level_limit;
		logic [7:0]  hold_count;
		logic [7:0]  round_tolerance;
	} cfg_t;

	// Classified sample handed from front to back.
	typedef struct packed {
		logic                        start;
		logic                        upright;
		logic signed [PROD_BITS-1:0] rate_x;
		logic signed [PROD_BITS-1:0] rate_y;
		logic signed [PROD_BITS-1:0] rate_z;
		logic signed [MAG_BITS-1:0]  mag_x;
		logic signed [MAG_BITS-1:0]  mag_y;
		logic signed [MAG_BITS-1:0]  mag_z;
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] cx;
		logic signed [OUT_BITS-1:0] cy;
		logic signed [OUT_BITS-1:0] cz;
		logic [2:0]                 phase;
		logic                       done;
	} res_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} link_t;

endpackage

FILE: hw/rtl/mag_hard_iron_calibrator.sv
// Top level of the magnetometer hard-iron calibrator.
// One word is accepted per clock while the front queue is not full, and each
// gives exactly one result word; the front scales the gyro rates by the
// sample period in its multipliers and queues the word, and the back runs the
// calibration sequencer on each word it takes and queues the result. Both
// sides are two-entry queues, so a stall on either side is absorbed until
// the queues fill, after which it stops the other side as well. The
// sequencer spins level (yaw), waits upright, spins upright (roll/pitch) and
// checks roundness; each result carries the offset-corrected field in the
// body frame, the phase and the done flag. Write configuration only while idle.
module mag_hard_iron_calibrator (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic op,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic signed [15:0] accel_z,
	input  logic signed [mhi_pkg::MAG_BITS-1:0] mag_x,
	input  logic signed [mhi_pkg::MAG_BITS-1:0] mag_y,
	input  logic signed [mhi_pkg::MAG_BITS-1:0] mag_z,
	output logic empty,
	input  logic pop,
	output logic signed [mhi_pkg::OUT_BITS-1:0] corrected_x,
	output logic signed [mhi_pkg::OUT_BITS-1:0] corrected_y,
	output logic signed [mhi_pkg::OUT_BITS-1:0] corrected_z,
	output logic [2:0] phase,
	output logic done_res,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mhi_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mhi_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import mhi_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	res_t  res;
	logic  lnk_valid;
	logic  lnk_ready;

	// register writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time       <= 16'd1311;
			cfg_q.turn_limit      <= 36'd2529944570;
			cfg_q.level_limit     <= 15'd384;
			cfg_q.hold_count      <= 8'd50;
			cfg_q.round_tolerance <= 8'd51;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP_TIME:  cfg_q.step_time       <= cfg_data[15:0];
				REG_TURN_LIMIT: cfg_q.turn_limit      <= cfg_data;
				REG_LEVEL:      cfg_q.level_limit     <= cfg_data[14:0];
				REG_HOLD:       cfg_q.hold_count      <= cfg_data[7:0];
				REG_ROUND_TOL:  cfg_q.round_tolerance <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mhi_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .push(push), .full(full), .op(op),
		.gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z), .accel_z(accel_z),
		.mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
		.take(lnk_ready), .avail(lnk_valid), .cmd(cmd)
	);

	mhi_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .avail(lnk_valid), .take(lnk_ready),
		.cmd(cmd), .pop(pop), .empty(empty), .res(res)
	);

	assign corrected_x = res.cx;
	assign corrected_y = res.cy;
	assign corrected_z = res.cz;
	assign phase       = res.phase;
	assign done_res    = res.done;
endmodule

FILE: hw/rtl/mhi_front.sv
// Front end: scale gyro rates, classify attitude and queue the words.
module mhi_front (
	input  logic               clk,
	input  logic               arst_n,
	input  mhi_pkg::cfg_t      cfg,
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic signed [15:0] accel_z,
	input  logic signed [mhi_pkg::MAG_BITS-1:0] mag_x,
	input  logic signed [mhi_pkg::MAG_BITS-1:0] mag_y,
	input  logic signed [mhi_pkg::MAG_BITS-1:0] mag_z,
	input  logic               take,
	output logic               avail,
	output mhi_pkg::cmd_t      cmd
);
	import mhi_pkg::*;

	cmd_t        ent_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	cmd_t        c;
	logic signed [16:0] step_s;
	logic [15:0] az_abs;
	logic        do_push, do_pop;

	always_comb begin
		step_s    = $signed({1'b0, cfg.step_time});
		az_abs    = accel_z[15] ? 16'(-accel_z) : 16'(accel_z);
		c.start   = op;
		c.upright = az_abs < {1'b0, cfg.level_limit};
		c.rate_x  = PROD_BITS'(gyro_x * step_s);
		c.rate_y  = PROD_BITS'(gyro_y * step_s);
		c.rate_z  = PROD_BITS'(gyro_z * step_s);
		c.mag_x   = mag_x;
		c.mag_y   = mag_y;
		c.mag_z   = mag_z;
	end

	assign full    = cnt_q == 2'd2;
	assign avail   = cnt_q != 2'd0;
	assign cmd     = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

FILE: hw/rtl/mhi_back.sv
// Back end: calibration sequencer, extreme tracking and result queue.
module mhi_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mhi_pkg::cfg_t cfg,
	input  logic          avail,
	output logic          take,
	input  mhi_pkg::cmd_t cmd,
	input  logic          pop,
	output logic          empty,
	output mhi_pkg::res_t res
);
	import mhi_pkg::*;

	localparam int AW = ANGLE_BITS + 1;
	localparam int RW = MAG_BITS + 11;
	localparam logic signed [MAG_BITS-1:0] MAG_MAX = {1'b0, {(MAG_BITS-1){1'b1}}};
	localparam logic signed [MAG_BITS-1:0] MAG_MIN = {1'b1, {(MAG_BITS-1){1'b0}}};
	localparam logic signed [ANGLE_BITS-1:0] ANG_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
	localparam logic signed [ANGLE_BITS-1:0] ANG_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	phase_t phase_q, phase_d;
	logic [7:0] cnt_q, cnt_d;
	logic signed [ANGLE_BITS-1:0] yaw_q, roll_q, pitch_q, yaw_d, roll_d, pitch_d;
	logic signed [MAG_BITS-1:0] max_q [3], min_q [3], off_q [3];
	logic signed [MAG_BITS-1:0] max_d [3], min_d [3], off_d [3];
	logic done_q, done_d, round_ok;
	res_t r;
	res_t ent_q [2];
	logic wr_q, rd_q;
	logic [1:0] ocnt_q;
	logic fire;

	function automatic logic signed [ANGLE_BITS-1:0] sat_add(
		input logic signed [ANGLE_BITS-1:0] a, input logic signed [PROD_BITS-1:0] b);
		logic signed [AW-1:0] s;
		s = AW'(a) + AW'(b);
		if (s > AW'(ANG_MAX)) return ANG_MAX;
		if (s < AW'(ANG_MIN)) return ANG_MIN;
		return s[ANGLE_BITS-1:0];
	endfunction

	function automatic logic over(input logic signed [ANGLE_BITS-1:0] a,
		input logic [35:0] lim);
		logic [ANGLE_BITS-1:0] m;
		m = a[ANGLE_BITS-1] ? ANGLE_BITS'(-a) : ANGLE_BITS'(a);
		return m > ANGLE_BITS'(lim);
	endfunction

	function automatic logic signed [MAG_BITS-1:0] mid(
		input logic signed [MAG_BITS-1:0] hi, input logic signed [MAG_BITS-1:0] lo);
		logic signed [MAG_BITS:0] s;
		s = (MAG_BITS+1)'(hi) + (MAG_BITS+1)'(lo);
		return s[MAG_BITS:1];
	endfunction

	function automatic logic [7:0] inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	// roundness check on the held extremes
	always_comb begin
		logic signed [MAG_BITS:0] xw, yw;
		logic signed [MAG_BITS+1:0] df;
		logic [RW-1:0] lhs, rhs;
		xw  = (MAG_BITS+1)'(max_q[0]) - (MAG_BITS+1)'(min_q[0]);
		yw  = (MAG_BITS+1)'(max_q[1]) - (MAG_BITS+1)'(min_q[1]);
		df  = (MAG_BITS+2)'(xw) - (MAG_BITS+2)'(yw);
		lhs = RW'(df[MAG_BITS+1] ? -df : df) << 8;
		rhs = RW'(cfg.round_tolerance) * RW'(yw[MAG_BITS-1:0]);
		round_ok = (xw > 0) && (yw > 0) && (lhs < rhs);
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		yaw_d   = yaw_q;
		roll_d  = roll_q;
		pitch_d = pitch_q;
		max_d   = max_q;
		min_d   = min_q;
		off_d   = off_q;
		done_d  = done_q;
		case (phase_q)
			PH_IDLE: begin
				yaw_d = '0; roll_d = '0; pitch_d = '0; cnt_d = '0;
				if (cmd.start) begin
					for (int i = 0; i < 3; i++) begin
						max_d[i] = MAG_MIN; min_d[i] = MAG_MAX;
					end
					done_d  = 1'b0;
					phase_d = PH_LEVEL;
				end
			end
			PH_LEVEL: begin
				yaw_d = sat_add(yaw_q, cmd.rate_z);
				if (over(yaw_d, cfg.turn_limit)) phase_d = PH_WAIT;
			end
			PH_WAIT: begin
				roll_d = '0; pitch_d = '0;
				cnt_d  = cmd.upright ? inc(cnt_q) : 8'd0;
				if (cnt_d > cfg.hold_count) begin
					phase_d = PH_UPRIGHT; cnt_d = '0;
				end
			end
			PH_UPRIGHT: begin
				roll_d  = sat_add(roll_q, cmd.rate_x);
				pitch_d = sat_add(pitch_q, cmd.rate_y);
				if (over(roll_d, cfg.turn_limit) || over(pitch_d, cfg.turn_limit))
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				cnt_d = inc(cnt_q);
				if (cnt_d > cfg.hold_count) begin
					phase_d = round_ok ? PH_SUCCESS : PH_FAIL;
					cnt_d   = '0;
				end
			end
			PH_FAIL: phase_d = PH_IDLE;
			PH_SUCCESS: begin
				cnt_d = inc(cnt_q);
				if (cnt_d > cfg.hold_count) phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
		case (phase_d)
			PH_LEVEL: begin
				if (cmd.mag_x > max_d[0]) max_d[0] = cmd.mag_x;
				if (cmd.mag_x < min_d[0]) min_d[0] = cmd.mag_x;
				if (cmd.mag_y > max_d[1]) max_d[1] = cmd.mag_y;
				if (cmd.mag_y < min_d[1]) min_d[1] = cmd.mag_y;
			end
			PH_WAIT: begin
				off_d[0] = mid(max_d[0], min_d[0]);
				off_d[1] = mid(max_d[1], min_d[1]);
			end
			PH_UPRIGHT: begin
				if (cmd.mag_z > max_d[2]) max_d[2] = cmd.mag_z;
				if (cmd.mag_z < min_d[2]) min_d[2] = cmd.mag_z;
			end
			PH_CHECK: begin
				off_d[2] = mid(max_d[2], min_d[2]);
				done_d   = round_ok;
			end
			default: ;
		endcase
		r.cx    = OUT_BITS'(off_d[1]) - OUT_BITS'(cmd.mag_y);
		r.cy    = OUT_BITS'(cmd.mag_x) - OUT_BITS'(off_d[0]);
		r.cz    = OUT_BITS'(cmd.mag_z) - OUT_BITS'(off_d[2]);
		r.phase = phase_d;
		r.done  = done_d;
	end

	assign take  = ocnt_q != 2'd2;
	assign fire  = take && avail;
	assign empty = ocnt_q == 2'd0;
	assign res   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (fire) ent_q[wr_q] <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			yaw_q   <= '0;
			roll_q  <= '0;
			pitch_q <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				max_q[i] <= MAG_MIN; min_q[i] <= MAG_MAX; off_q[i] <= '0;
			end
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				yaw_q   <= yaw_d;
				roll_q  <= roll_d;
				pitch_q <= pitch_d;
				done_q  <= done_d;
				max_q   <= max_d;
				min_q   <= min_d;
				off_q   <= off_d;
				wr_q    <= !wr_q;
			end
			if (pop && !empty) rd_q <= !rd_q;
			ocnt_q <= ocnt_q + 2'(fire) - 2'(pop && !empty);
		end
	end
endmodule

FILE: hw/rtl/mhi_checker.sv
// Port-level checks for the calibrator, bound to the top level.
module mhi_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic cfg_ready,
	input logic [2:0] phase,
	input logic done_res,
	input logic signed [mhi_pkg::OUT_BITS-1:0] corrected_x
);
	import mhi_pkg::*;

	a_no_spare: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> phase != PH_SPARE) else $error("spare phase shown");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("register write stalled");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(phase) && $stable(done_res)))
		else $error("waiting flags changed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(corrected_x))) else $error("result dropped");
endmodule

bind mag_hard_iron_calibrator mhi_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .cfg_ready(cfg_ready),
	.phase(phase), .done_res(done_res), .corrected_x(corrected_x)
);
